// ----- rtl/core/petb_pkg.sv -----
// Package for the periodic event timer bank: channel count, field widths,
// item kind codes and the controller-to-datapath command and status types.
// No dependencies.
package petb_pkg;

    // Number of timer channels and the bits needed to index one
    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed by the request format
    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int STEP_W   = 10;
    localparam int TIME_W   = 32;

    // Reset values
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(1024);
    localparam logic [STEP_W-1:0]   RESET_STEP   = STEP_W'(10);

    // Request kinds; the two codes above KIND_TIME are unused and do nothing
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_SET    = 3'd1,
        KIND_READ   = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_TCLR   = 3'd4,
        KIND_TIME   = 3'd5
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            capture;   // latch the accepted request
        logic            scan;      // visit one channel for a tick
        logic [CH_W-1:0] scan_idx;  // channel visited
        logic            commit;    // apply the request and load the result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_busy;             // result register full and not taken
    } t_stat;

endpackage

// ----- rtl/core/petb_ctrl.sv -----
// Controller of the periodic event timer bank: accepts requests, steps the
// shared decrementer through the channels on a tick and commits the result.
// Depends on petb_pkg.
module petb_ctrl
    import petb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_tick,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_idx, n_idx;

    // State and channel counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.scan_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_idx         = '0;
                    n_state       = i_in_tick ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_EXEC;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the result
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_stat.out_busy)
        else $error("commit while result register busy");

    // A tick request starts its scan at channel zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.capture && i_in_tick) |=> (o_cmd.scan && o_cmd.scan_idx == '0))
        else $error("scan did not start at channel zero");

    // The scan visits channels in order without gaps
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && o_cmd.scan_idx != CH_W'(CHANNELS - 1))
            |=> (o_cmd.scan && o_cmd.scan_idx == $past(o_cmd.scan_idx) + 1'b1))
        else $error("scan skipped a channel");

    // No new request is captured while a request is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_cmd.capture)
        else $error("request captured while busy");
`endif

endmodule

// ----- rtl/core/petb_dpath.sv -----
// Datapath of the periodic event timer bank: channel counters, reload values,
// sticky flags, system time, time step register and the result register.
// Depends on petb_pkg.
module petb_dpath
    import petb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [CHAN_W-1:0]   i_chan,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_flag_value,
    output logic [TIME_W-1:0]   o_system_time
);

    logic [KIND_W-1:0]   r_kind;
    logic [CHAN_W-1:0]   r_chan;
    logic [PERIOD_W-1:0] r_period;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_time;
    logic [PERIOD_W-1:0] r_count  [CHANNELS];
    logic [PERIOD_W-1:0] r_reload [CHANNELS];
    logic [CHANNELS-1:0] r_flag;
    logic                r_out_valid;
    logic                r_out_flag;
    logic [TIME_W-1:0]   r_out_time;

    logic                present;
    logic [CH_W-1:0]     ch;
    logic                flag_hit;
    logic [TIME_W-1:0]   n_time;
    logic                n_out_flag;

    // Decode the latched request
    assign present  = (32'(r_chan) < CHANNELS);
    assign ch       = CH_W'(r_chan);
    assign flag_hit = present && (r_kind == KIND_SET || r_kind == KIND_READ ||
                                  r_kind == KIND_CLEAR || r_kind == KIND_TCLR);
    assign n_out_flag = flag_hit ? r_flag[ch] : 1'b0;
    assign n_time     = (r_kind == KIND_TICK) ? r_time + TIME_W'(r_step) : r_time;

    // Latch the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_chan   <= i_chan;
            r_period <= i_period;
        end
    end

    // Time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= RESET_STEP;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    // System time: advance once per tick at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cmd.commit) begin
            r_time <= n_time;
        end
    end

    // Channel state: one channel per scan cycle, or the addressed one at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i]  <= RESET_PERIOD;
                r_reload[i] <= RESET_PERIOD;
            end
            r_flag <= '0;
        end else if (i_cmd.scan) begin
            if (r_count[i_cmd.scan_idx] != '0) begin
                r_count[i_cmd.scan_idx] <= r_count[i_cmd.scan_idx] - 1'b1;
            end else begin
                r_count[i_cmd.scan_idx] <= r_reload[i_cmd.scan_idx];
                r_flag[i_cmd.scan_idx]  <= 1'b1;
            end
        end else if (i_cmd.commit && present) begin
            case (r_kind)
                KIND_SET: begin
                    r_count[ch]  <= r_period;
                    r_reload[ch] <= r_period;
                    r_flag[ch]   <= 1'b0;
                end
                KIND_CLEAR, KIND_TCLR: begin
                    r_flag[ch] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: load at commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_flag <= n_out_flag;
            r_out_time <= n_time;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_flag_value    = r_out_flag;
    assign o_system_time   = r_out_time;

endmodule

// ----- rtl/core/periodic_event_timer_bank.sv -----
// Top level of the periodic event timer bank: stream ports, controller and
// datapath. Depends on petb_pkg, petb_ctrl and petb_dpath.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid/tready           tuser: kind; tdata: channel, period
//  m_axis    out  tvalid/tready           tdata: flag_value, system_time
//  cfg       in   i_cfg_we                i_cfg_wdata: time_step
//
// A tick passes through an accept step, a scan of every channel in turn through the
// shared decrementer, and a commit step.
// Every other request passes through accept and commit.
// One request is in flight at a time; the result register lets the next request
// be accepted while a result waits. A stalled result register holds the commit.
// Reset is synchronous, active low, and loads every channel with period 1024.
module periodic_event_timer_bank
    import petb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [23:0]   s_axis_tdata,   // [2:0] channel, [18:3] period, rest zero
    input  logic [2:0]    s_axis_tuser,   // [2:0] kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [39:0]   m_axis_tdata,   // [0] flag_value, [32:1] system_time, rest zero
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_wdata
);

    t_cmd              cmd;
    t_stat             stat;
    logic              out_flag;
    logic [TIME_W-1:0] out_time;

    petb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_tick  (s_axis_tuser == KIND_TICK),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    petb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (s_axis_tuser),
        .i_chan        (s_axis_tdata[2:0]),
        .i_period      (s_axis_tdata[18:3]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_flag_value  (out_flag),
        .o_system_time (out_time)
    );

    // Pack the result
    assign m_axis_tdata = {7'd0, out_time, out_flag};

endmodule
